// ===== sv/indexed_list_store_top_macros.svh =====
// Assertion macros shared by the list store RTL
`ifndef INDEXED_LIST_STORE_TOP_MACROS_SVH
`define INDEXED_LIST_STORE_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset
`define ILS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define ILS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ils_pkg.sv =====
// Shared constants and types for the indexed list store
package ils_pkg;

	// Default sizing
	localparam int unsigned CAPACITY_DEF     = 64;
	localparam int unsigned ELEMENT_BITS_DEF = 32;

	// Fixed port widths
	localparam int unsigned CMD_BITS     = 3;
	localparam int unsigned POS_BITS     = 7;
	localparam int unsigned ELEM_IN_BITS = 32;
	localparam int unsigned VALUE_BITS   = 32;
	localparam int unsigned FPOS_BITS    = 6;
	localparam int unsigned COUNT_BITS   = 7;

	// Command codes
	typedef enum logic [CMD_BITS-1:0] {
		CMD_APPEND    = 3'd0,
		CMD_INSERT    = 3'd1,
		CMD_OVERWRITE = 3'd2,
		CMD_READ      = 3'd3,
		CMD_REMOVE    = 3'd4,
		CMD_SEARCH    = 3'd5,
		CMD_CLEAR     = 3'd6
	} cmd_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_FINAL,
		ST_RDWAIT,
		ST_SEARCH,
		ST_DONE
	} state_t;

endpackage

// ===== sv/ils_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module ils_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/indexed_list_store_top.sv =====
// Indexed list store: an ordered list of nonzero words in one RAM, worked by a small
// sequencer. Every command takes one word and gives one result word. Insert at the end
// of the list and remove of the last entry move no other entries, and search stops at
// the first match. The entry RAM has a single read port and a single write port, and
// shifting moves one entry per cycle. The block is not ready while a command is in
// progress; a finished result sits in an output register, so the next word can be taken
// while it waits. No clearing pass is needed after reset.
`include "indexed_list_store_top_macros.svh"

module indexed_list_store_top #(
	parameter int unsigned CAPACITY     = ils_pkg::CAPACITY_DEF,
	parameter int unsigned ELEMENT_BITS = ils_pkg::ELEMENT_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Command channel
	input  logic                              cmd_valid,
	output logic                              cmd_ready,
	input  logic [ils_pkg::CMD_BITS-1:0]      command,
	input  logic [ils_pkg::POS_BITS-1:0]      position,
	input  logic [ils_pkg::ELEM_IN_BITS-1:0]  element,
	// Response channel
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic                              status,
	output logic [ils_pkg::VALUE_BITS-1:0]    value,
	output logic                              found,
	output logic [ils_pkg::FPOS_BITS-1:0]     found_position,
	output logic [ils_pkg::COUNT_BITS-1:0]    count
);

	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned PW = (CW > ils_pkg::POS_BITS) ? CW : ils_pkg::POS_BITS;

	ils_pkg::state_t state_q, state_d;
	ils_pkg::cmd_t   cmd_q;

	logic [CW-1:0]           count_q;
	logic [IW-1:0]           pos_q;
	logic [ELEMENT_BITS-1:0] elem_q;
	logic [IW-1:0]           scan_q;
	logic [IW-1:0]           dst_q;
	logic                    more_q;
	logic                    pend_q;

	// Result being built
	logic                          res_status_q;
	logic [ils_pkg::VALUE_BITS-1:0] res_value_q;
	logic                          res_found_q;
	logic [IW-1:0]                 res_fpos_q;

	// Output register
	logic                           rsp_valid_q;
	logic                           status_q;
	logic [ils_pkg::VALUE_BITS-1:0] value_q;
	logic                           found_q;
	logic [ils_pkg::FPOS_BITS-1:0]  fpos_q;
	logic [ils_pkg::COUNT_BITS-1:0] count_out_q;

	// RAM port signals
	logic                    ram_wr_en;
	logic [IW-1:0]           ram_wr_addr;
	logic [ELEMENT_BITS-1:0] ram_wr_data;
	logic                    ram_rd_en;
	logic [IW-1:0]           ram_rd_addr;
	logic [ELEMENT_BITS-1:0] ram_rd_data;

	// Decode of the incoming word
	logic                    accept;
	logic [ELEMENT_BITS-1:0] elem_in;
	logic                    elem_nz;
	logic [PW-1:0]           pos_in;
	logic [PW-1:0]           n_ext;
	logic                    pos_lt;
	logic                    pos_le;
	logic                    pos_eq;
	logic                    not_full;
	logic                    cmd_ok;

	// Sequencer helpers
	logic shift_last;
	logic search_last;
	logic hit;
	logic rsp_free;

	assign accept    = cmd_valid && cmd_ready;
	assign cmd_ready = (state_q == ils_pkg::ST_IDLE);
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign hit       = (ram_rd_data == elem_q);

	// Bounds and element checks for the incoming word
	always_comb begin
		elem_in  = ELEMENT_BITS'(element);
		elem_nz  = |elem_in;
		pos_in   = PW'(position);
		n_ext    = PW'(count_q);
		pos_lt   = pos_in < n_ext;
		pos_le   = pos_in <= n_ext;
		pos_eq   = pos_in == n_ext;
		not_full = count_q != CW'(CAPACITY);
		case (command)
			ils_pkg::CMD_APPEND:    cmd_ok = elem_nz && not_full;
			ils_pkg::CMD_INSERT:    cmd_ok = elem_nz && not_full && pos_le;
			ils_pkg::CMD_OVERWRITE: cmd_ok = elem_nz && pos_lt;
			ils_pkg::CMD_READ:      cmd_ok = pos_lt;
			ils_pkg::CMD_REMOVE:    cmd_ok = pos_lt;
			ils_pkg::CMD_SEARCH:    cmd_ok = elem_nz;
			ils_pkg::CMD_CLEAR:     cmd_ok = 1'b1;
			default:                cmd_ok = 1'b0;
		endcase
	end

	// Last read of a shift or a scan
	always_comb begin
		if (cmd_q == ils_pkg::CMD_INSERT) begin
			shift_last = (scan_q == pos_q);
		end else begin
			shift_last = (CW'(scan_q) == count_q);
		end
		search_last = ((CW'(scan_q) + CW'(1)) == count_q);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ils_pkg::ST_IDLE: begin
				if (accept) begin
					if (!cmd_ok) begin
						state_d = ils_pkg::ST_DONE;
					end else begin
						case (command)
							ils_pkg::CMD_INSERT:
								state_d = pos_eq ? ils_pkg::ST_DONE : ils_pkg::ST_SHIFT;
							ils_pkg::CMD_READ:   state_d = ils_pkg::ST_RDWAIT;
							ils_pkg::CMD_REMOVE: state_d = ils_pkg::ST_RDWAIT;
							ils_pkg::CMD_SEARCH:
								state_d = (count_q == '0) ? ils_pkg::ST_DONE
								                          : ils_pkg::ST_SEARCH;
							default:             state_d = ils_pkg::ST_DONE;
						endcase
					end
				end
			end
			ils_pkg::ST_SHIFT: begin
				if (!more_q && pend_q) begin
					state_d = (cmd_q == ils_pkg::CMD_INSERT) ? ils_pkg::ST_FINAL
					                                        : ils_pkg::ST_DONE;
				end
			end
			ils_pkg::ST_FINAL: state_d = ils_pkg::ST_DONE;
			ils_pkg::ST_RDWAIT: begin
				if (cmd_q == ils_pkg::CMD_REMOVE && CW'(pos_q) < count_q) begin
					state_d = ils_pkg::ST_SHIFT;
				end else begin
					state_d = ils_pkg::ST_DONE;
				end
			end
			ils_pkg::ST_SEARCH: begin
				if (pend_q && (hit || !more_q)) begin
					state_d = ils_pkg::ST_DONE;
				end
			end
			ils_pkg::ST_DONE: begin
				if (rsp_free) begin
					state_d = ils_pkg::ST_IDLE;
				end
			end
			default: state_d = ils_pkg::ST_IDLE;
		endcase
	end

	// RAM port control
	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = '0;
		ram_wr_data = elem_in;
		ram_rd_en   = 1'b0;
		ram_rd_addr = '0;
		case (state_q)
			ils_pkg::ST_IDLE: begin
				if (accept && cmd_ok) begin
					case (command)
						ils_pkg::CMD_APPEND: begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = IW'(count_q);
						end
						ils_pkg::CMD_INSERT: begin
							ram_wr_en   = pos_eq;
							ram_wr_addr = IW'(position);
						end
						ils_pkg::CMD_OVERWRITE: begin
							ram_wr_en   = 1'b1;
							ram_wr_addr = IW'(position);
						end
						ils_pkg::CMD_READ: begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = IW'(position);
						end
						ils_pkg::CMD_REMOVE: begin
							ram_rd_en   = 1'b1;
							ram_rd_addr = IW'(position);
						end
						default: ;
					endcase
				end
			end
			ils_pkg::ST_SHIFT: begin
				ram_rd_en   = more_q;
				ram_rd_addr = scan_q;
				ram_wr_en   = pend_q;
				ram_wr_addr = dst_q;
				ram_wr_data = ram_rd_data;
			end
			ils_pkg::ST_FINAL: begin
				ram_wr_en   = 1'b1;
				ram_wr_addr = pos_q;
				ram_wr_data = elem_q;
			end
			ils_pkg::ST_SEARCH: begin
				ram_rd_en   = more_q;
				ram_rd_addr = scan_q;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ils_pkg::ST_IDLE;
			count_q     <= '0;
			more_q      <= 1'b0;
			pend_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ils_pkg::ST_IDLE: begin
					more_q <= 1'b1;
					pend_q <= 1'b0;
					if (accept && cmd_ok) begin
						case (command)
							ils_pkg::CMD_APPEND: count_q <= count_q + CW'(1);
							ils_pkg::CMD_INSERT: count_q <= count_q + CW'(1);
							ils_pkg::CMD_REMOVE: count_q <= count_q - CW'(1);
							ils_pkg::CMD_CLEAR:  count_q <= '0;
							default: ;
						endcase
					end
				end
				ils_pkg::ST_SHIFT: begin
					pend_q <= more_q;
					if (more_q && shift_last) begin
						more_q <= 1'b0;
					end
				end
				ils_pkg::ST_RDWAIT: begin
					more_q <= 1'b1;
					pend_q <= 1'b0;
				end
				ils_pkg::ST_SEARCH: begin
					pend_q <= more_q;
					if (more_q && search_last) begin
						more_q <= 1'b0;
					end
				end
				default: ;
			endcase
			if (state_q == ils_pkg::ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ils_pkg::ST_IDLE: begin
				if (accept) begin
					cmd_q        <= ils_pkg::cmd_t'(command);
					pos_q        <= IW'(position);
					elem_q       <= elem_in;
					res_status_q <= !cmd_ok;
					res_value_q  <= '0;
					res_found_q  <= 1'b0;
					res_fpos_q   <= '0;
					if (command == ils_pkg::CMD_INSERT) begin
						scan_q <= IW'(count_q - CW'(1));
					end else begin
						scan_q <= '0;
					end
				end
			end
			ils_pkg::ST_SHIFT: begin
				if (more_q) begin
					if (cmd_q == ils_pkg::CMD_INSERT) begin
						dst_q  <= scan_q + IW'(1);
						scan_q <= scan_q - IW'(1);
					end else begin
						dst_q  <= scan_q - IW'(1);
						scan_q <= scan_q + IW'(1);
					end
				end
			end
			ils_pkg::ST_RDWAIT: begin
				res_value_q <= ils_pkg::VALUE_BITS'(ram_rd_data);
				scan_q      <= pos_q + IW'(1);
			end
			ils_pkg::ST_SEARCH: begin
				if (more_q) begin
					dst_q  <= scan_q;
					scan_q <= scan_q + IW'(1);
				end
				if (pend_q && hit) begin
					res_found_q <= 1'b1;
					res_fpos_q  <= dst_q;
				end
			end
			default: ;
		endcase
		if (state_q == ils_pkg::ST_DONE && rsp_free) begin
			status_q    <= res_status_q;
			value_q     <= res_value_q;
			found_q     <= res_found_q;
			fpos_q      <= ils_pkg::FPOS_BITS'(res_fpos_q);
			count_out_q <= ils_pkg::COUNT_BITS'(count_q);
		end
	end

	// Entry storage
	ils_ram #(
		.WIDTH (ELEMENT_BITS),
		.DEPTH (CAPACITY)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign value          = value_q;
	assign found          = found_q;
	assign found_position = fpos_q;
	assign count          = count_out_q;

	// Checks
	`ILS_ASSERT_NXT(a_busy_after_accept, accept, !cmd_ready, "ready held after accepting a word")

	`ILS_ASSERT_NOW(a_count_in_range, 1'b1, count_q <= CW'(CAPACITY), "entry count above capacity")

	`ILS_ASSERT_NOW(a_no_rw_clash, ram_rd_en && ram_wr_en, ram_rd_addr != ram_wr_addr, "read and write hit the same entry")

	`ILS_ASSERT_NOW(a_write_states, ram_wr_en, state_q == ils_pkg::ST_IDLE || state_q == ils_pkg::ST_SHIFT || state_q == ils_pkg::ST_FINAL, "entry write outside a writing state")

endmodule

// ===== tb/indexed_list_store_top_tb.sv =====
// Self-checking testbench for the indexed list store: directed, full-list and random command words
module indexed_list_store_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ils_pkg::*;

	localparam int unsigned LIST_CAP = CAPACITY_DEF;
	// Command code the package leaves unassigned
	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 3'd7;
	localparam int IDLE_PERCENT = 13;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_WORDS = 1150;

	// One response word, field by field
	typedef struct packed {
		logic                  status;
		logic [VALUE_BITS-1:0] value;
		logic                  found;
		logic [FPOS_BITS-1:0]  found_position;
		logic [COUNT_BITS-1:0] count;
	} list_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cmd_valid = 1'b0;
	logic                    cmd_ready;
	logic [CMD_BITS-1:0]     command = '0;
	logic [POS_BITS-1:0]     position = '0;
	logic [ELEM_IN_BITS-1:0] element = '0;
	logic                    rsp_valid;
	logic                    rsp_ready = 1'b0;
	logic                    status;
	logic [VALUE_BITS-1:0]   value;
	logic                    found;
	logic [FPOS_BITS-1:0]    found_position;
	logic [COUNT_BITS-1:0]   count;

	// Shadow copy of the list contents
	logic [ELEM_IN_BITS-1:0] shadow_entries [LIST_CAP];
	int unsigned             shadow_count = 0;

	list_result_t awaited_results [$];
	bit           quiet_mode = 1'b0;
	int           mismatches = 0;
	int           words_sent = 0;
	int           rejected_words = 0;
	int           search_hits = 0;
	int unsigned  deepest_list = 0;
	int           cmd_tally [8];
	int           stalled_cycles = 0;

	indexed_list_store_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.command        (command),
		.position       (position),
		.element        (element),
		.rsp_valid      (rsp_valid),
		.rsp_ready      (rsp_ready),
		.status         (status),
		.value          (value),
		.found          (found),
		.found_position (found_position),
		.count          (count)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Apply one command to the shadow list and work out the response word
	function automatic list_result_t predict_list_result(input logic [CMD_BITS-1:0] cmd,
			input logic [POS_BITS-1:0] pos, input logic [ELEM_IN_BITS-1:0] elem);
		list_result_t r;
		int           n;
		int           p;
		int           i;
		r = '0;
		r.status = 1'b1;
		n = shadow_count;
		p = pos;
		case (cmd)
			CMD_APPEND: begin
				if (elem != '0 && n < LIST_CAP) begin
					shadow_entries[n] = elem;
					shadow_count = n + 1;
					r.status = 1'b0;
				end
			end
			CMD_INSERT: begin
				if (elem != '0 && n < LIST_CAP && p <= n) begin
					for (i = n; i > p; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[p] = elem;
					shadow_count = n + 1;
					r.status = 1'b0;
				end
			end
			CMD_OVERWRITE: begin
				if (elem != '0 && p < n) begin
					shadow_entries[p] = elem;
					r.status = 1'b0;
				end
			end
			CMD_READ: begin
				if (p < n) begin
					r.value = shadow_entries[p];
					r.status = 1'b0;
				end
			end
			CMD_REMOVE: begin
				if (p < n) begin
					r.value = shadow_entries[p];
					for (i = p; i + 1 < n; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count = n - 1;
					r.status = 1'b0;
				end
			end
			CMD_SEARCH: begin
				// first match wins
				if (elem != '0) begin
					r.status = 1'b0;
					for (i = 0; i < n; i++) begin
						if (!r.found && shadow_entries[i] == elem) begin
							r.found = 1'b1;
							r.found_position = i[FPOS_BITS-1:0];
						end
					end
				end
			end
			CMD_CLEAR: begin
				shadow_count = 0;
				r.status = 1'b0;
			end
			default: ;
		endcase
		r.count = shadow_count[COUNT_BITS-1:0];
		return r;
	endfunction

	// Offer one command word, hold it until taken, then record the expected response
	task automatic send_word(input logic [CMD_BITS-1:0] cmd, input logic [POS_BITS-1:0] pos,
			input logic [ELEM_IN_BITS-1:0] elem);
		list_result_t r;
		@(negedge clk);
		while (!quiet_mode && $urandom_range(99) < IDLE_PERCENT) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		command   <= cmd;
		position  <= pos;
		element   <= elem;
		@(posedge clk);
		while (!cmd_ready) @(posedge clk);
		r = predict_list_result(cmd, pos, elem);
		awaited_results.push_back(r);
		words_sent++;
		cmd_tally[cmd]++;
		if (r.status) rejected_words++;
		if (r.found) search_hits++;
		if (shadow_count > deepest_list) deepest_list = shadow_count;
	endtask

	// Element choice: list members for hits, a small pool for duplicates, or any word
	function automatic logic [ELEM_IN_BITS-1:0] pick_element();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 30 && shadow_count > 0)
			return shadow_entries[$urandom_range(shadow_count - 1)];
		if (r < 60)
			return ELEM_IN_BITS'($urandom_range(6, 1));
		if (r < 65)
			return '1;
		return ELEM_IN_BITS'($urandom());
	endfunction

	function automatic logic [POS_BITS-1:0] valid_index(input int unsigned n);
		return (n == 0) ? '0 : POS_BITS'($urandom_range(n - 1));
	endfunction

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Every command and each corner on a short list
	task automatic test_directed_cases();
		send_word(CMD_READ, 7'd0, 32'd0);
		send_word(CMD_REMOVE, 7'd0, 32'd0);
		send_word(CMD_SEARCH, 7'd0, 32'd5);
		send_word(CMD_APPEND, 7'd0, 32'd0);
		send_word(CMD_APPEND, 7'd0, 32'hFFFF_FFFF);
		send_word(CMD_APPEND, 7'd127, 32'd1);
		send_word(CMD_INSERT, 7'd0, 32'hA5A5_0001);
		send_word(CMD_INSERT, 7'd3, 32'd2);
		send_word(CMD_INSERT, 7'd2, 32'h8000_0000);
		send_word(CMD_INSERT, 7'd6, 32'd9);
		send_word(CMD_INSERT, 7'd0, 32'd0);
		send_word(CMD_OVERWRITE, 7'd1, 32'h1234_5678);
		send_word(CMD_OVERWRITE, 7'd0, 32'd0);
		send_word(CMD_OVERWRITE, 7'd5, 32'd3);
		send_word(CMD_READ, 7'd4, 32'd0);
		send_word(CMD_READ, 7'd5, 32'd0);
		send_word(CMD_SEARCH, 7'd0, 32'hFFFF_FFFF);
		send_word(CMD_SEARCH, 7'd0, 32'd0);
		send_word(CMD_SEARCH, 7'd0, 32'hDEAD_BEEF);
		send_word(CMD_REMOVE, 7'd4, 32'd0);
		send_word(CMD_REMOVE, 7'd1, 32'd0);
		send_word(CMD_REMOVE, 7'd0, 32'd0);
		send_word(CMD_UNUSED, 7'd127, 32'h5555_AAAA);
		send_word(CMD_CLEAR, 7'd0, 32'd0);
		send_word(CMD_READ, 7'd0, 32'd0);
	endtask

	// Fill to capacity, then the full-list errors and the longest shifts and searches
	task automatic test_full_list();
		int k;
		for (k = 0; k < LIST_CAP; k++)
			send_word(CMD_APPEND, 7'd0, ELEM_IN_BITS'($urandom_range(32'hFFFF_FFFF, 1)));
		send_word(CMD_APPEND, 7'd0, 32'd7);
		send_word(CMD_INSERT, 7'd0, 32'd7);
		send_word(CMD_INSERT, 7'd64, 32'd7);
		send_word(CMD_READ, 7'd63, 32'd0);
		send_word(CMD_READ, 7'd64, 32'd0);
		send_word(CMD_SEARCH, 7'd0, shadow_entries[LIST_CAP-1]);
		send_word(CMD_OVERWRITE, 7'd63, 32'hFFFF_FFFF);
		send_word(CMD_REMOVE, 7'd0, 32'd0);
		send_word(CMD_INSERT, 7'd0, 32'h0000_0001);
		send_word(CMD_REMOVE, 7'd63, 32'd0);
		send_word(CMD_INSERT, 7'd63, 32'hC3C3_C3C3);
		send_word(CMD_SEARCH, 7'd0, 32'hC3C3_C3C3);
		send_word(CMD_CLEAR, 7'd0, 32'd0);
	endtask

	// Mostly well-formed commands, list length steered towards a moving target
	task automatic test_random_traffic(input int words);
		int                      k;
		int unsigned             r;
		int unsigned             n;
		int unsigned             fill_target;
		bit                      grow;
		logic [ELEM_IN_BITS-1:0] elem;
		fill_target = 16;
		for (k = 0; k < words; k++) begin
			quiet_mode = (k >= 400 && k < 600);
			if (k % 100 == 0) begin
				case ($urandom_range(3))
					0: fill_target = 4;
					1: fill_target = 16;
					2: fill_target = 40;
					default: fill_target = LIST_CAP;
				endcase
			end
			n = shadow_count;
			grow = (n < fill_target);
			r = $urandom_range(99);
			elem = pick_element();
			if (r < 8) begin
				// noise: any code, any index, zero elements now and then
				send_word(CMD_BITS'($urandom_range(7)), POS_BITS'($urandom_range(127)),
					($urandom_range(3) == 0) ? '0 : elem);
			end else if (r < 9) begin
				send_word(CMD_CLEAR, POS_BITS'($urandom_range(127)), elem);
			end else if (r < (grow ? 50 : 25)) begin
				if ($urandom_range(1))
					send_word(CMD_APPEND, POS_BITS'($urandom_range(127)), elem);
				else
					send_word(CMD_INSERT, POS_BITS'($urandom_range(n)), elem);
			end else if (r < (grow ? 60 : 55)) begin
				send_word(CMD_REMOVE, valid_index(n), elem);
			end else begin
				case (r % 3)
					0: send_word(CMD_OVERWRITE, valid_index(n), elem);
					1: send_word(CMD_READ, valid_index(n), elem);
					default: send_word(CMD_SEARCH, POS_BITS'($urandom_range(127)), elem);
				endcase
			end
		end
		quiet_mode = 1'b0;
	endtask

	// Response side back-pressure
	always @(negedge clk) begin
		rsp_ready <= quiet_mode ? 1'b1 : ($urandom_range(99) >= IDLE_PERCENT);
	end

	// Compare each response word against the oldest expectation
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t ns: response word with nothing awaited, count 0x%0h", $time, count);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("status", 32'(want.status), 32'(status));
				check_field("value", want.value, value);
				check_field("found", 32'(want.found), 32'(found));
				check_field("found_position", 32'(want.found_position),
					32'(found_position));
				check_field("count", 32'(want.count), 32'(count));
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel
	always @(posedge clk) begin
		if (!arst_n) begin
			stalled_cycles <= 0;
		end else if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready)) begin
			stalled_cycles <= 0;
		end else begin
			stalled_cycles <= stalled_cycles + 1;
			if (stalled_cycles >= STALL_LIMIT) begin
				$display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
				$display("indexed_list_store_top_tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_full_list();
		test_random_traffic(RANDOM_WORDS);

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_results.size() != 0) begin
			$display("%0t ns: %0d responses never arrived", $time, awaited_results.size());
			mismatches++;
		end

		$display("Sent %0d command words (%0d rejected), %0d search hits, list depth up to %0d",
			words_sent, rejected_words, search_hits, deepest_list);
		$display("Per code: app %0d ins %0d ovw %0d rd %0d rem %0d srch %0d clr %0d unused %0d",
			cmd_tally[0], cmd_tally[1], cmd_tally[2], cmd_tally[3], cmd_tally[4],
			cmd_tally[5], cmd_tally[6], cmd_tally[7]);
		if (mismatches == 0)
			$display("indexed_list_store_top_tb OK");
		else
			$display("indexed_list_store_top_tb NOT OK");
		$finish;
	end

endmodule
